>>> hdl/lgw_pkg.sv
// Package for the LED gradient wave colour generator.
// Holds command, register and direction codes, fixed field widths and the sequencer states.
// No dependencies.
package lgw_pkg;

   // Field widths of the stream and register ports.
   localparam int CMD_W       = 2;
   localparam int RGB_W       = 24;
   localparam int REQ_DATA_W  = 72;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Geometry is carried with 16 fraction bits.
   localparam int GEOM_FRAC = 16;
   // Root width: squared distances stay below 2^54.
   localparam int ROOT_W = 27;
   // Denominator 100 * cols stays below 2^16.
   localparam int DEN_W = 16;
   localparam logic [6:0] DEN_SCALE = 7'd100;

   // Centre in Q.16: floor(P * 65536 / 100) = 655 * P + floor(9 * P / 25), with
   // floor(v / 25) = (v * 1342178) >> 25 exact for v below 2^20.
   localparam logic [9:0]  CENTRE_INT   = 10'd655;
   localparam logic [3:0]  CENTRE_NINE  = 4'd9;
   localparam logic [20:0] RECIP_25     = 21'd1342178;
   localparam int          RECIP_SHIFT  = 25;

   localparam logic [CMD_W-1:0] CMD_COLOUR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPREAD     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_COL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_ROW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP       = 3'd4;

   localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
   localparam logic [1:0] MODE_VERTICAL   = 2'd1;
   localparam logic [1:0] MODE_RADIAL_OUT = 2'd2;
   localparam logic [1:0] MODE_RADIAL_IN  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CENTRE,
      ST_DIST,
      ST_SQUARE,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_INDEX,
      ST_OUT
   } state_type;

endpackage

>>> hdl/lgw_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Keeps only the low QUO_W quotient bits. Uses no package.
module lgw_div #(
   parameter int NUM_W = 37,
   parameter int DEN_W = 16,
   parameter int QUO_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quot_ff, quot_in;

   logic [DEN_W:0] rem_shift;
   logic [DEN_W:0] rem_diff;
   logic           fits;

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = num;
         den_in   = den;
         rem_in   = '0;
         quot_in  = '0;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so its top bit drops away.
         rem_in   = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         quot_in  = {quot_ff[QUO_W-2:0], fits};
         num_in   = {num_ff[NUM_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> hdl/lgw_sqrt.sv
// Iterative integer square root, one root bit per cycle, truncating.
// Input is 2*ROOT_W bits wide. Uses no package.
module lgw_sqrt #(
   parameter int ROOT_W = 27
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*ROOT_W-1:0] value,
   output logic                done,
   output logic [ROOT_W-1:0]   root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [2*ROOT_W-1:0] val_ff, val_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [ROOT_W+3:0] rem_shift;
   logic [ROOT_W+3:0] trial;
   logic [ROOT_W+3:0] rem_diff;
   logic              fits;

   // Bring down the next bit pair and try root*4 + 1.
   assign rem_shift = {rem_ff, val_ff[2*ROOT_W-1 -: 2]};
   assign trial     = (ROOT_W + 4)'({root_ff, 2'b01});
   assign fits      = rem_shift >= trial;
   assign rem_diff  = rem_shift - trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         val_in   = value;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         // The remainder never exceeds twice the partial root.
         rem_in   = fits ? rem_diff[ROOT_W+1:0] : rem_shift[ROOT_W+1:0];
         root_in  = {root_ff[ROOT_W-2:0], fits};
         val_in   = {val_ff[2*ROOT_W-3:0], 2'b00};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      val_ff   <= val_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> hdl/led_gradient_wave_colour.sv
// Table writes and frame ticks are done on acceptance; the next transaction is taken right after.
// A colour transaction runs through the bit-serial divider in the linear modes and through
// the bit-serial square root and then the divider in the radial modes; one colour is in work
// at a time.
// Reset clears the phase and restores register defaults; the gradient memory is not cleared.
// Depends on lgw_pkg, lgw_div and lgw_sqrt.
module led_gradient_wave_colour #(
   parameter int GRADIENT_POINTS = 100,
   parameter int COORD_BITS      = 8,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // led_x[7:0], led_y[15:8], zone_cols[24:16], zone_rows[33:25], mirror[34],
   // entry_index[41:35], entry_rgb[65:42], zero[71:66]
   input  logic [lgw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd[1:0]
   input  logic [lgw_pkg::CMD_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // led_rgb[23:0]
   output logic [lgw_pkg::RGB_W-1:0]       rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lgw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lgw_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int F      = PHASE_FRAC_BITS;
   localparam int IDX_W  = $clog2(GRADIENT_POINTS);
   localparam int NUM_W  = F + 21;
   localparam int D_W    = F + 11;
   localparam int ROOT_W = lgw_pkg::ROOT_W;
   localparam logic [7:0] COORD_MASK = 8'((1 << COORD_BITS) - 1);

   // Request fields.
   logic [7:0]  in_x, in_y;
   logic [8:0]  in_cols, in_rows, in_cols_eff, in_rows_eff, in_x_mirr;
   logic        in_mirror;
   logic [6:0]  in_entry_index;
   logic [23:0] in_entry_rgb;

   assign in_x           = req_tdata[7:0] & COORD_MASK;
   assign in_y           = req_tdata[15:8] & COORD_MASK;
   assign in_cols        = req_tdata[24:16];
   assign in_rows        = req_tdata[33:25];
   assign in_mirror      = req_tdata[34];
   assign in_entry_index = req_tdata[41:35];
   assign in_entry_rgb   = req_tdata[65:42];
   assign in_cols_eff    = (in_cols == 9'd0) ? 9'd1 : in_cols;
   assign in_rows_eff    = (in_rows == 9'd0) ? 9'd1 : in_rows;

   always_comb begin
      in_x_mirr = {1'b0, in_x};
      if (in_mirror) begin
         in_x_mirr = ({1'b0, in_x} < in_cols_eff) ? (in_cols_eff - 9'd1 - {1'b0, in_x}) : 9'd0;
      end
   end

   // Configuration registers.
   logic [1:0]  mode_ff;
   logic [9:0]  spread_ff;
   logic [6:0]  centre_col_ff, centre_row_ff;
   logic [15:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= lgw_pkg::MODE_HORIZONTAL;
         spread_ff     <= 10'd100;
         centre_col_ff <= 7'd50;
         centre_row_ff <= 7'd50;
         step_ff       <= 16'd273;
      end else if (csr_valid) begin
         case (csr_index)
            lgw_pkg::CSR_DIRECTION:  mode_ff       <= csr_data[1:0];
            lgw_pkg::CSR_SPREAD:     spread_ff     <= csr_data[9:0];
            lgw_pkg::CSR_CENTRE_COL: centre_col_ff <= csr_data[6:0];
            lgw_pkg::CSR_CENTRE_ROW: centre_row_ff <= csr_data[6:0];
            lgw_pkg::CSR_STEP:       step_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Sequencer and datapath registers.
   lgw_pkg::state_type state_ff, state_in;
   logic [F-1:0]       phase_ff, phase_in;
   logic [8:0]         x_ff, x_in;
   logic [7:0]         y_ff, y_in;
   logic [8:0]         cols_ff, cols_in;
   logic [8:0]         rows_ff, rows_in;
   logic [lgw_pkg::DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [15:0]        col_prod_ff, col_prod_in;
   logic [15:0]        row_prod_ff, row_prod_in;
   logic [25:0]        cx_ff, cx_in;
   logic [25:0]        cy_ff, cy_in;
   logic [25:0]        dx_ff, dx_in;
   logic [25:0]        dy_ff, dy_in;
   logic [52:0]        sumsq_ff, sumsq_in;
   logic [F-1:0]       pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;
   logic [23:0]        rd_data_ff;

   logic accept;
   logic div_start, div_done, sqrt_start, sqrt_done, rd_en, out_load;
   logic [F-1:0]      div_quot;
   logic [ROOT_W-1:0] sqrt_root;

   assign accept = req_tvalid && req_tready;

   // Combinational datapath pieces.
   logic [F+15:0]  step_wide;
   logic [F-1:0]   step_frac;
   logic [8:0]     lin_coord;
   logic [18:0]    lin_prod;
   logic [18+F:0]  lin_num;
   logic [19:0]    col_nine, row_nine;
   logic [40:0]    col_rcp, row_rcp;
   logic [25:0]    x_q, y_q;
   logic [51:0]    dx_sq, dy_sq;
   logic [ROOT_W+F-1:0] d_wide;
   logic [D_W-1:0] d_val;
   logic [F-1:0]   frac;
   logic [F+IDX_W-1:0] idx_prod;
   logic [IDX_W-1:0]   rd_addr;

   assign step_wide = {step_ff, {F{1'b0}}};
   assign step_frac = step_wide[F+15:16];
   assign lin_coord = (mode_ff == lgw_pkg::MODE_VERTICAL) ? {1'b0, y_ff} : x_ff;
   assign lin_prod  = 19'(spread_ff) * 19'(lin_coord);
   assign lin_num   = {lin_prod, {F{1'b0}}};
   assign col_nine  = 20'(col_prod_ff) * 20'(lgw_pkg::CENTRE_NINE);
   assign row_nine  = 20'(row_prod_ff) * 20'(lgw_pkg::CENTRE_NINE);
   assign col_rcp   = 41'(col_nine) * 41'(lgw_pkg::RECIP_25);
   assign row_rcp   = 41'(row_nine) * 41'(lgw_pkg::RECIP_25);
   assign x_q       = {1'b0, x_ff, 16'b0};
   assign y_q       = {2'b0, y_ff, 16'b0};
   assign dx_sq     = 52'(dx_ff) * 52'(dx_ff);
   assign dy_sq     = 52'(dy_ff) * 52'(dy_ff);
   assign d_wide    = {sqrt_root, {F{1'b0}}};
   assign d_val     = d_wide[ROOT_W+F-1:lgw_pkg::GEOM_FRAC];
   // Radial out runs against the phase, everything else with it.
   assign frac      = (mode_ff == lgw_pkg::MODE_RADIAL_OUT) ? (phase_ff - pos_ff)
                                                            : (phase_ff + pos_ff);
   assign idx_prod  = (F + IDX_W)'(frac) * (F + IDX_W)'(GRADIENT_POINTS);
   assign rd_addr   = idx_prod[F+IDX_W-1:F];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lgw_pkg::ST_IDLE: begin
            if (accept && req_tuser == lgw_pkg::CMD_COLOUR) begin
               state_in = lgw_pkg::ST_SETUP;
            end
         end
         lgw_pkg::ST_SETUP: begin
            if (mode_ff == lgw_pkg::MODE_RADIAL_OUT || mode_ff == lgw_pkg::MODE_RADIAL_IN) begin
               state_in = lgw_pkg::ST_CENTRE;
            end else begin
               state_in = lgw_pkg::ST_DIV_START;
            end
         end
         lgw_pkg::ST_CENTRE:     state_in = lgw_pkg::ST_DIST;
         lgw_pkg::ST_DIST:       state_in = lgw_pkg::ST_SQUARE;
         lgw_pkg::ST_SQUARE:     state_in = lgw_pkg::ST_SQRT_START;
         lgw_pkg::ST_SQRT_START: state_in = lgw_pkg::ST_SQRT_WAIT;
         lgw_pkg::ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               state_in = lgw_pkg::ST_DIV_START;
            end
         end
         lgw_pkg::ST_DIV_START:  state_in = lgw_pkg::ST_DIV_WAIT;
         lgw_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = lgw_pkg::ST_INDEX;
            end
         end
         lgw_pkg::ST_INDEX:      state_in = lgw_pkg::ST_OUT;
         lgw_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = lgw_pkg::ST_IDLE;
            end
         end
         default:                state_in = lgw_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      rd_en      = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         lgw_pkg::ST_IDLE:       req_tready = 1'b1;
         lgw_pkg::ST_SQRT_START: sqrt_start = 1'b1;
         lgw_pkg::ST_DIV_START:  div_start  = 1'b1;
         lgw_pkg::ST_INDEX:      rd_en      = 1'b1;
         lgw_pkg::ST_OUT:        out_load   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      phase_in     = phase_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      col_prod_in  = col_prod_ff;
      row_prod_in  = row_prod_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sumsq_in     = sumsq_ff;
      pos_in       = pos_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (accept && req_tuser == lgw_pkg::CMD_TICK) begin
         phase_in = phase_ff + step_frac;
      end
      if (accept && req_tuser == lgw_pkg::CMD_COLOUR) begin
         x_in    = in_x_mirr;
         y_in    = in_y;
         cols_in = in_cols_eff;
         rows_in = in_rows_eff;
      end
      case (state_ff)
         lgw_pkg::ST_SETUP: begin
            den_in = (mode_ff == lgw_pkg::MODE_VERTICAL)
                     ? 16'(16'(lgw_pkg::DEN_SCALE) * 16'(rows_ff))
                     : 16'(16'(lgw_pkg::DEN_SCALE) * 16'(cols_ff));
            num_in      = NUM_W'(lin_num);
            col_prod_in = 16'(16'(cols_ff - 9'd1) * 16'(centre_col_ff));
            row_prod_in = 16'(16'(rows_ff - 9'd1) * 16'(centre_row_ff));
         end
         lgw_pkg::ST_CENTRE: begin
            cx_in = 26'(26'(col_prod_ff) * 26'(lgw_pkg::CENTRE_INT))
                    + 26'(col_rcp >> lgw_pkg::RECIP_SHIFT);
            cy_in = 26'(26'(row_prod_ff) * 26'(lgw_pkg::CENTRE_INT))
                    + 26'(row_rcp >> lgw_pkg::RECIP_SHIFT);
         end
         lgw_pkg::ST_DIST: begin
            dx_in = (x_q >= cx_ff) ? (x_q - cx_ff) : (cx_ff - x_q);
            dy_in = (y_q >= cy_ff) ? (y_q - cy_ff) : (cy_ff - y_q);
         end
         lgw_pkg::ST_SQUARE: begin
            sumsq_in = 53'(dx_sq) + 53'(dy_sq);
         end
         lgw_pkg::ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               num_in = NUM_W'(NUM_W'(spread_ff) * NUM_W'(d_val));
            end
         end
         lgw_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               pos_in = div_quot;
            end
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_data_in  = rd_data_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgw_pkg::ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      cols_ff     <= cols_in;
      rows_ff     <= rows_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      col_prod_ff <= col_prod_in;
      row_prod_ff <= row_prod_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sumsq_ff    <= sumsq_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Gradient memory: writes come only from idle transactions and reads only from the
   // index step, so the two never meet in one cycle.
   logic [23:0] grad_mem [GRADIENT_POINTS];

   always_ff @(posedge clock) begin
      if (accept && req_tuser == lgw_pkg::CMD_WRITE
          && 32'(in_entry_index) < GRADIENT_POINTS) begin
         grad_mem[IDX_W'(in_entry_index)] <= in_entry_rgb;
      end
      if (rd_en) begin
         rd_data_ff <= grad_mem[rd_addr];
      end
   end

   lgw_div #(
      .NUM_W (NUM_W),
      .DEN_W (lgw_pkg::DEN_W),
      .QUO_W (F)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   lgw_sqrt #(
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value ({1'b0, sumsq_ff}),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for led_gradient_wave_colour: table loads, frame ticks and
// per-LED colour requests, checked against a wave colour predictor in this file.
// Depends on lgw_pkg and the led_gradient_wave_colour RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned WAVE_POINTS = 100;
   localparam int unsigned PERCENT     = 100;
   localparam int unsigned PHASE_BITS  = 16;
   localparam logic [lgw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned PHASE_ITEMS = 200;

   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [8:0]  cols;
      logic [8:0]  rows;
      logic        mirror;
      logic [6:0]  entry;
      logic [23:0] rgb;
   } led_req_type;

   typedef struct {
      led_req_type req;
      bit          fixed;
      logic [23:0] fixed_rgb;
   } led_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [lgw_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [lgw_pkg::CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lgw_pkg::RGB_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lgw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lgw_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Predictor state and register copy.
   logic [23:0] grad_table [WAVE_POINTS];
   logic [15:0] wave_phase = '0;
   logic [1:0]  cfg_mode = lgw_pkg::MODE_HORIZONTAL;
   logic [9:0]  cfg_spread = 10'd100;
   logic [6:0]  cfg_centre_col = 7'd50;
   logic [6:0]  cfg_centre_row = 7'd50;
   logic [15:0] cfg_step = 16'd273;

   logic [23:0] pending_rgb [$];
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned rsp_hold_left = 0;

   always #6 clock = ~clock;

   led_gradient_wave_colour u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      error_count++;
      $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Colour of one LED for the current phase, registers and gradient table.
   function automatic logic [23:0] wave_colour(input led_req_type it);
      longint unsigned x, y, cols, rows, pos, cx, cy, dx, dy, radius, frac, idx;
      x = it.x;
      y = it.y;
      cols = (it.cols == 0) ? 1 : it.cols;
      rows = (it.rows == 0) ? 1 : it.rows;
      if (it.mirror) x = (x < cols) ? cols - 1 - x : 0;
      case (cfg_mode)
         lgw_pkg::MODE_HORIZONTAL: pos = ((cfg_spread * x) << PHASE_BITS) / (PERCENT * cols);
         lgw_pkg::MODE_VERTICAL:   pos = ((cfg_spread * y) << PHASE_BITS) / (PERCENT * rows);
         default: begin
            cx = (((cols - 1) * cfg_centre_col) << 16) / PERCENT;
            cy = (((rows - 1) * cfg_centre_row) << 16) / PERCENT;
            dx = ((x << 16) >= cx) ? (x << 16) - cx : cx - (x << 16);
            dy = ((y << 16) >= cy) ? (y << 16) - cy : cy - (y << 16);
            radius = int_sqrt(dx * dx + dy * dy);
            pos = (cfg_spread * radius) / (PERCENT * cols);
         end
      endcase
      // Radial out runs the wave away from the centre, so the position is subtracted.
      if (cfg_mode == lgw_pkg::MODE_RADIAL_OUT) frac = (wave_phase - pos) & 64'hFFFF;
      else frac = (wave_phase + pos) & 64'hFFFF;
      idx = (frac * WAVE_POINTS) >> PHASE_BITS;
      return grad_table[idx];
   endfunction

   function automatic led_req_type make_req(input logic [1:0] cmd, input logic [7:0] x,
                                            input logic [7:0] y, input logic [8:0] cols,
                                            input logic [8:0] rows, input logic mirror,
                                            input logic [6:0] entry, input logic [23:0] rgb);
      led_req_type it;
      it.cmd = cmd;
      it.x = x;
      it.y = y;
      it.cols = cols;
      it.rows = rows;
      it.mirror = mirror;
      it.entry = entry;
      it.rgb = rgb;
      return it;
   endfunction

   function automatic led_req_type random_item();
      led_req_type it;
      int unsigned pick;
      int unsigned span;
      bit strip;
      it = make_req(CMD_UNUSED, 8'($urandom()), 8'($urandom()), 9'($urandom()),
                    9'($urandom()), 1'($urandom()), 7'($urandom()), 24'($urandom()));
      pick = $urandom_range(99);
      if (pick < 60) begin
         it.cmd = lgw_pkg::CMD_COLOUR;
         pick = $urandom_range(99);
         if (pick < 70) it.cols = 9'($urandom_range(64, 1));
         else if (pick < 80) it.cols = 9'd256;
         else if (pick < 90) it.cols = 9'($urandom_range(256, 1));
         strip = ($urandom_range(3) == 0);
         if (strip) begin
            it.rows = 9'd1;
            it.y = 8'd0;
         end else if ($urandom_range(9) != 0) begin
            it.rows = 9'($urandom_range(64, 1));
         end
         // Mostly coordinates inside the zone, some anywhere in the field.
         span = (it.cols == 0) ? 1 : ((it.cols > 256) ? 256 : it.cols);
         if ($urandom_range(9) != 0) it.x = 8'($urandom_range(span - 1));
         span = (it.rows == 0) ? 1 : ((it.rows > 256) ? 256 : it.rows);
         if (!strip && $urandom_range(9) != 0) it.y = 8'($urandom_range(span - 1));
      end else if (pick < 75) begin
         it.cmd = lgw_pkg::CMD_WRITE;
         if ($urandom_range(9) != 0) it.entry = 7'($urandom_range(WAVE_POINTS - 1));
      end else if (pick < 96) begin
         it.cmd = lgw_pkg::CMD_TICK;
      end
      return it;
   endfunction

   task automatic send_item(input led_req_type it, input bit fixed,
                            input logic [23:0] fixed_rgb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.cmd;
      req_tdata <= {6'd0, it.rgb, it.entry, it.mirror, it.rows, it.cols, it.y, it.x};
      do @(posedge clock); while (!req_tready);
      // The transaction is taken at this edge; update the predictor in the same order.
      case (it.cmd)
         lgw_pkg::CMD_COLOUR: pending_rgb.push_back(fixed ? fixed_rgb : wave_colour(it));
         lgw_pkg::CMD_WRITE:  if (it.entry < WAVE_POINTS) grad_table[it.entry] = it.rgb;
         lgw_pkg::CMD_TICK:   wave_phase = wave_phase + cfg_step;
         default: ;
      endcase
   endtask

   task automatic wait_results_done(input int unsigned settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lgw_pkg::CSR_INDEX_W-1:0] index,
                            input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         lgw_pkg::CSR_DIRECTION:  cfg_mode = value[1:0];
         lgw_pkg::CSR_SPREAD:     cfg_spread = value[9:0];
         lgw_pkg::CSR_CENTRE_COL: cfg_centre_col = value[6:0];
         lgw_pkg::CSR_CENTRE_ROW: cfg_centre_row = value[6:0];
         lgw_pkg::CSR_STEP:       cfg_step = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [1:0] mode, input int unsigned spread,
                               input int unsigned col_pct, input int unsigned row_pct,
                               input int unsigned step);
      write_reg(lgw_pkg::CSR_DIRECTION, 16'(mode));
      write_reg(lgw_pkg::CSR_SPREAD, 16'(spread));
      write_reg(lgw_pkg::CSR_CENTRE_COL, 16'(col_pct));
      write_reg(lgw_pkg::CSR_CENTRE_ROW, 16'(row_pct));
      write_reg(lgw_pkg::CSR_STEP, 16'(step));
   endtask

   // Result side: check each accepted transaction, then decide the next ready.
   initial begin
      logic [23:0] want_rgb;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_rgb.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, '0);
            end else begin
               want_rgb = pending_rgb.pop_front();
               if (rsp_tdata !== want_rgb) report_mismatch("led_rgb", rsp_tdata, want_rgb);
            end
         end
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #(15_000_000);
      $display("** led_gradient_wave_colour: FAILED **");
      $finish;
   end

   initial begin
      led_row_type directed_q [$];
      led_req_type it;
      int unsigned counted;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole gradient table so that no colour ever reads an unwritten entry.
      for (int i = 0; i < WAVE_POINTS; i++)
         send_item(make_req(lgw_pkg::CMD_WRITE, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 7'(i),
                            {8'(i), 8'(255 - i), 8'h5A}), 1'b0, '0);

      // Directed rows, run with the register values after reset.
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd0, 8'd0, 9'd1, 9'd1, 1'b0, 7'd0,
                                      24'd0), 1'b1, 24'h00FF5A});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd255, 8'd255, 9'd256, 9'd256,
                                      1'b0, 7'd0, 24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd5, 8'd3, 9'd0, 9'd0, 1'b0, 7'd0,
                                      24'd0), 1'b1, 24'h00FF5A});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd200, 8'd0, 9'd10, 9'd1, 1'b1,
                                      7'd0, 24'd0), 1'b1, 24'h00FF5A});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd255, 8'd0, 9'd256, 9'd1, 1'b1,
                                      7'd0, 24'd0), 1'b1, 24'h00FF5A});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd3, 8'd0, 9'd10, 9'd1, 1'b1, 7'd0,
                                      24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd255, 8'd255, 9'd511, 9'd511,
                                      1'b0, 7'd0, 24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_WRITE, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 7'd0,
                                      24'hFFFFFF), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd0, 8'd0, 9'd1, 9'd1, 1'b0, 7'd0,
                                      24'd0), 1'b1, 24'hFFFFFF});
      directed_q.push_back('{make_req(lgw_pkg::CMD_WRITE, 8'hFF, 8'hFF, 9'h1FF, 9'h1FF, 1'b1,
                                      7'd0, 24'h000000), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd0, 8'd0, 9'd1, 9'd1, 1'b0, 7'd0,
                                      24'd0), 1'b1, 24'h000000});
      // Writes past the end of the table are dropped.
      directed_q.push_back('{make_req(lgw_pkg::CMD_WRITE, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 7'd127,
                                      24'h123456), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_WRITE, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 7'd100,
                                      24'hABCDEF), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_WRITE, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 7'd99,
                                      24'hFFFFFF), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd255, 8'd0, 9'd256, 9'd1, 1'b0,
                                      7'd0, 24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(CMD_UNUSED, 8'hFF, 8'hFF, 9'h1FF, 9'h1FF, 1'b1, 7'h7F,
                                      24'hFFFFFF), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_TICK, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 7'd0,
                                      24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd0, 8'd0, 9'd1, 9'd1, 1'b0, 7'd0,
                                      24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd128, 8'd7, 9'd200, 9'd9, 1'b1,
                                      7'd0, 24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_TICK, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 7'd0,
                                      24'd0), 1'b0, 24'd0});
      directed_q.push_back('{make_req(lgw_pkg::CMD_COLOUR, 8'd255, 8'd0, 9'd1, 9'd1, 1'b0,
                                      7'd0, 24'd0), 1'b0, 24'd0});
      foreach (directed_q[i])
         send_item(directed_q[i].req, directed_q[i].fixed, directed_q[i].fixed_rgb);

      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         wait_results_done(100);
         case (p)
            0: program_regs(lgw_pkg::MODE_HORIZONTAL, 1000, 0, 100, 65535);
            1: program_regs(lgw_pkg::MODE_VERTICAL, 0, 100, 0, 0);
            2: program_regs(lgw_pkg::MODE_RADIAL_OUT, 1000, 0, 100, 1);
            3: program_regs(lgw_pkg::MODE_RADIAL_IN, 1000, 100, 0, 65535);
            default: program_regs(2'($urandom_range(3)), $urandom_range(1000),
                                  $urandom_range(100), $urandom_range(100),
                                  $urandom_range(65535));
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         // Hold the result side off while requests keep coming, so the input backs up.
         if (p == 4) rsp_hold_left = 600;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            it = random_item();
            send_item(it, 1'b0, '0);
            if (it.cmd != CMD_UNUSED
                && !(it.cmd == lgw_pkg::CMD_WRITE && it.entry >= WAVE_POINTS)) begin
               counted++;
               if (counted % 97 == 0) wait_results_done(0);
            end
         end
      end

      wait_results_done(120);
      if (error_count == 0 && pending_rgb.size() == 0) begin
         $display("** led_gradient_wave_colour: PASSED **");
      end else begin
         $display("** led_gradient_wave_colour: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/lgw_pkg.sv
hdl/lgw_div.sv
hdl/lgw_sqrt.sv
hdl/led_gradient_wave_colour.sv
sim/testbench.sv
